/* src/blpol_pkg.sv */
// Shared types, register map, colour and power-state codes for the battery LED policy.
// No dependencies; used by every module of the block.
package blpol_pkg;

    localparam int PHASE_BITS = 8;
    localparam int PERIOD_W   = 8;
    localparam int CMP_W      = (PHASE_BITS > PERIOD_W) ? PHASE_BITS : PERIOD_W;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [PERIOD_W-1:0]   period_t;
    typedef logic [1:0]            color_t;

    localparam color_t COLOR_OFF   = 2'd0;
    localparam color_t COLOR_AMBER = 2'd1;
    localparam color_t COLOR_WHITE = 2'd2;

    localparam logic [2:0] PS_CHARGE      = 3'd0;
    localparam logic [2:0] PS_DISCHARGE   = 3'd1;
    localparam logic [2:0] PS_ERROR       = 3'd2;
    localparam logic [2:0] PS_NEAR_FULL   = 3'd3;
    localparam logic [2:0] PS_IDLE        = 3'd4;
    localparam logic [2:0] PS_FORCED_IDLE = 3'd5;

    localparam logic signed [1:0] PORT_RIGHT = 2'sd0;
    localparam logic signed [1:0] PORT_LEFT  = 2'sd1;

    localparam logic [2:0] REG_NO_POWER_LED  = 3'd0;
    localparam logic [2:0] REG_LOW_BATT      = 3'd1;
    localparam logic [2:0] REG_BLINK_PERIOD  = 3'd2;
    localparam logic [2:0] REG_BLINK_ON      = 3'd3;
    localparam logic [2:0] REG_SUSP_PERIOD   = 3'd4;
    localparam logic [2:0] REG_SUSP_ON       = 3'd5;

    localparam logic [6:0] RST_LOW_BATT     = 7'd10;
    localparam period_t    RST_BLINK_PERIOD = 8'd4;
    localparam period_t    RST_BLINK_ON     = 8'd2;
    localparam period_t    RST_SUSP_PERIOD  = 8'd4;
    localparam period_t    RST_SUSP_ON      = 8'd2;

    typedef struct packed {
        logic       no_power_led_flag_off;
        logic [6:0] low_battery_threshold;
        period_t    blink_period;
        period_t    blink_on_ticks;
        period_t    suspend_period;
        period_t    suspend_on_ticks;
    } cfg_t;

    typedef struct packed {
        logic             in_suspend;
        logic [2:0]       power_state;
        logic [6:0]       battery_percent;
        logic signed [1:0] active_port;
        logic             right_auto;
        logic             left_auto;
    } item_t;

    function automatic phase_t advance_phase(phase_t phase, period_t period);
        phase_t           nx;
        logic [CMP_W-1:0] nx_w;
        logic [CMP_W-1:0] per_w;
        begin
            nx    = phase + 1'b1;
            nx_w  = CMP_W'(nx);
            per_w = CMP_W'(period);
            advance_phase = (nx_w >= per_w) ? '0 : nx;
        end
    endfunction

    function automatic logic phase_lit(phase_t phase, period_t on_ticks);
        begin
            phase_lit = CMP_W'(phase) < CMP_W'(on_ticks);
        end
    endfunction

endpackage

/* src/battery_led_indicator_policy.sv */
// Top level of the battery LED policy: input register, tick policy and result register.
// Depends on blpol_pkg, blpol_cfg and blpol_core.
// An input beat passes through the input register, then the result register, to become a result beat.
// Throughput: one tick beat per cycle while m_ready takes each result; the result register frees as it is taken.
// Reset (aresetn low, synchronous): both channels empty, phases and parity zero,
// both held LED colours off (the result register is not reset), settings at their documented defaults.
module battery_led_indicator_policy (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blpol_pkg::ADDR_W-1:0]  paddr,
    input  logic [blpol_pkg::DATA_W-1:0]  pwdata,
    output logic [blpol_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_in_suspend,
    input  logic [2:0]                    s_power_state,
    input  logic [6:0]                    s_battery_percent,
    input  logic signed [1:0]             s_active_port,
    input  logic                          s_right_auto,
    input  logic                          s_left_auto,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_right_color,
    output logic [1:0]                    m_left_color
);

    blpol_pkg::cfg_t   cfg;
    blpol_pkg::item_t  item_reg;
    logic              item_vld_reg;
    logic              out_vld_reg;
    blpol_pkg::color_t right_out_reg;
    blpol_pkg::color_t left_out_reg;
    blpol_pkg::color_t right_next;
    blpol_pkg::color_t left_next;
    logic              step;

    assign step          = item_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready       = !item_vld_reg || step;
    assign m_valid       = out_vld_reg;
    assign m_right_color = right_out_reg;
    assign m_left_color  = left_out_reg;

    blpol_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blpol_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (item_reg),
        .cfg        (cfg),
        .right_next (right_next),
        .left_next  (left_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                item_vld_reg <= s_valid;
            end
            if (step) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.in_suspend      <= s_in_suspend;
            item_reg.power_state     <= s_power_state;
            item_reg.battery_percent <= s_battery_percent;
            item_reg.active_port     <= s_active_port;
            item_reg.right_auto      <= s_right_auto;
            item_reg.left_auto       <= s_left_auto;
        end
        if (step) begin
            right_out_reg <= right_next;
            left_out_reg  <= left_next;
        end
    end

endmodule

/* src/blpol_cfg.sv */
// APB register file for the battery LED policy settings.
// Depends on blpol_pkg for the register map and the cfg_t bundle.
module blpol_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blpol_pkg::ADDR_W-1:0]  paddr,
    input  logic [blpol_pkg::DATA_W-1:0]  pwdata,
    output logic [blpol_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output blpol_pkg::cfg_t               cfg
);

    blpol_pkg::cfg_t cfg_reg;
    blpol_pkg::cfg_t cfg_next;
    logic [2:0]      idx;
    logic            wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                blpol_pkg::REG_NO_POWER_LED: cfg_next.no_power_led_flag_off = pwdata[0];
                blpol_pkg::REG_LOW_BATT:     cfg_next.low_battery_threshold = pwdata[6:0];
                blpol_pkg::REG_BLINK_PERIOD: cfg_next.blink_period          = pwdata[7:0];
                blpol_pkg::REG_BLINK_ON:     cfg_next.blink_on_ticks        = pwdata[7:0];
                blpol_pkg::REG_SUSP_PERIOD:  cfg_next.suspend_period        = pwdata[7:0];
                blpol_pkg::REG_SUSP_ON:      cfg_next.suspend_on_ticks      = pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            blpol_pkg::REG_NO_POWER_LED:
                prdata = blpol_pkg::DATA_W'(cfg_reg.no_power_led_flag_off);
            blpol_pkg::REG_LOW_BATT:
                prdata = blpol_pkg::DATA_W'(cfg_reg.low_battery_threshold);
            blpol_pkg::REG_BLINK_PERIOD: prdata = blpol_pkg::DATA_W'(cfg_reg.blink_period);
            blpol_pkg::REG_BLINK_ON:     prdata = blpol_pkg::DATA_W'(cfg_reg.blink_on_ticks);
            blpol_pkg::REG_SUSP_PERIOD:  prdata = blpol_pkg::DATA_W'(cfg_reg.suspend_period);
            blpol_pkg::REG_SUSP_ON:      prdata = blpol_pkg::DATA_W'(cfg_reg.suspend_on_ticks);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.no_power_led_flag_off <= 1'b0;
            cfg_reg.low_battery_threshold <= blpol_pkg::RST_LOW_BATT;
            cfg_reg.blink_period          <= blpol_pkg::RST_BLINK_PERIOD;
            cfg_reg.blink_on_ticks        <= blpol_pkg::RST_BLINK_ON;
            cfg_reg.suspend_period        <= blpol_pkg::RST_SUSP_PERIOD;
            cfg_reg.suspend_on_ticks      <= blpol_pkg::RST_SUSP_ON;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/blpol_core.sv */
// Tick policy: phase counters, parity and held LED colours, updated once per beat.
// Depends on blpol_pkg for types, codes and the phase helpers.
module blpol_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  blpol_pkg::item_t    item,
    input  blpol_pkg::cfg_t     cfg,
    output blpol_pkg::color_t   right_next,
    output blpol_pkg::color_t   left_next
);

    blpol_pkg::phase_t blink_phase_reg;
    blpol_pkg::phase_t blink_phase_next;
    blpol_pkg::phase_t susp_phase_reg;
    blpol_pkg::phase_t susp_phase_next;
    logic              parity_reg;
    logic              parity_next;
    blpol_pkg::color_t right_reg;
    blpol_pkg::color_t left_reg;

    logic              susp_mode;
    logic              lit;
    logic              is_right;
    logic              is_left;
    blpol_pkg::color_t both_c;
    blpol_pkg::color_t port_c;
    logic              use_both;
    logic              use_port;

    assign blink_phase_next = blpol_pkg::advance_phase(blink_phase_reg, cfg.blink_period);
    assign parity_next      = ~parity_reg;
    assign susp_mode        = !cfg.no_power_led_flag_off && item.in_suspend
                              && (item.power_state != blpol_pkg::PS_CHARGE);
    assign lit              = blpol_pkg::phase_lit(blink_phase_next, cfg.blink_on_ticks);
    assign is_right         = item.active_port == blpol_pkg::PORT_RIGHT;
    assign is_left          = item.active_port == blpol_pkg::PORT_LEFT;

    always_comb begin
        both_c   = blpol_pkg::COLOR_OFF;
        port_c   = blpol_pkg::COLOR_OFF;
        use_both = 1'b0;
        use_port = 1'b0;
        case (item.power_state)
            blpol_pkg::PS_CHARGE: begin
                use_port = 1'b1;
                port_c   = blpol_pkg::COLOR_AMBER;
            end
            blpol_pkg::PS_DISCHARGE: begin
                use_both = 1'b1;
                if ((item.battery_percent < cfg.low_battery_threshold) && lit) begin
                    both_c = blpol_pkg::COLOR_AMBER;
                end
            end
            blpol_pkg::PS_ERROR: begin
                use_both = 1'b1;
                both_c   = parity_next ? blpol_pkg::COLOR_AMBER : blpol_pkg::COLOR_OFF;
            end
            blpol_pkg::PS_NEAR_FULL, blpol_pkg::PS_IDLE: begin
                use_port = 1'b1;
                port_c   = blpol_pkg::COLOR_WHITE;
            end
            blpol_pkg::PS_FORCED_IDLE: begin
                use_port = 1'b1;
                port_c   = lit ? blpol_pkg::COLOR_AMBER : blpol_pkg::COLOR_OFF;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        right_next      = right_reg;
        left_next       = left_reg;
        susp_phase_next = '0;
        if (susp_mode) begin
            susp_phase_next = blpol_pkg::advance_phase(susp_phase_reg, cfg.suspend_period);
            right_next = blpol_pkg::phase_lit(susp_phase_next, cfg.suspend_on_ticks)
                         ? blpol_pkg::COLOR_WHITE : blpol_pkg::COLOR_OFF;
            left_next  = right_next;
        end else begin
            if (item.right_auto) begin
                if (use_both) begin
                    right_next = both_c;
                end else if (use_port) begin
                    right_next = is_right ? port_c : blpol_pkg::COLOR_OFF;
                end
            end
            if (item.left_auto) begin
                if (use_both) begin
                    left_next = both_c;
                end else if (use_port) begin
                    left_next = is_left ? port_c : blpol_pkg::COLOR_OFF;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_phase_reg <= '0;
            susp_phase_reg  <= '0;
            parity_reg      <= 1'b0;
            right_reg       <= blpol_pkg::COLOR_OFF;
            left_reg        <= blpol_pkg::COLOR_OFF;
        end else if (step) begin
            blink_phase_reg <= blink_phase_next;
            susp_phase_reg  <= susp_phase_next;
            parity_reg      <= parity_next;
            right_reg       <= right_next;
            left_reg        <= left_next;
        end
    end

endmodule
